// ===== hdl/sro_pkg.sv =====
package sro_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_ROI_X_MIN    = 3'd0;
	localparam logic [2:0] REG_ROI_X_MAX    = 3'd1;
	localparam logic [2:0] REG_ROI_Y_MIN    = 3'd2;
	localparam logic [2:0] REG_ROI_Y_MAX    = 3'd3;
	localparam logic [2:0] REG_HIT_THRESH   = 3'd4;
	localparam logic [2:0] REG_RANGE_FLOOR  = 3'd5;
	localparam logic [2:0] REG_RANGE_CEIL   = 3'd6;
	localparam logic [2:0] REG_ANGLE_STEP   = 3'd7;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 17;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;

	// Polynomial coefficients, Q30
	localparam logic [63:0] Q30_ONE = 64'd1073741824;
	localparam logic [63:0] C1 = 64'd1686629713;
	localparam logic [63:0] C3 = 64'd693598668;
	localparam logic [63:0] C5 = 64'd85569306;
	localparam logic [63:0] C7 = 64'd5026995;
	localparam logic [63:0] C9 = 64'd172272;

	// One request as it leaves the front
	typedef struct packed {
		logic [15:0] range_mm;
		logic        in_window;
		logic        last;
	} item_t;

	// Range window and angle step used by the front
	typedef struct packed {
		logic [15:0] floor_mm;
		logic [15:0] ceil_mm;
		logic [15:0] step;
	} window_t;

	// Region bounds and threshold used by the back
	typedef struct packed {
		logic signed [16:0] x_min;
		logic signed [16:0] x_max;
		logic signed [16:0] y_min;
		logic signed [16:0] y_max;
		logic [12:0]        threshold;
	} roi_t;

	// Quarter-wave sine, u in 0..16384, result Q16 in 0..65536
	function automatic logic [16:0] quarter_sine(input logic [14:0] u);
		logic [63:0] t;
		logic [63:0] t2;
		logic [63:0] s;
		logic [63:0] v;
		t  = 64'(u) << 16;
		t2 = (t * t) >> 30;
		s  = C9;
		s  = C7 - ((t2 * s) >> 30);
		s  = C5 - ((t2 * s) >> 30);
		s  = C3 - ((t2 * s) >> 30);
		s  = C1 - ((t2 * s) >> 30);
		v  = (t * s) >> 30;
		if (v > Q30_ONE) begin
			v = Q30_ONE;
		end
		v = (v + 64'd8192) >> 14;
		if (v > 64'd65536) begin
			v = 64'd65536;
		end
		return v[16:0];
	endfunction

	// Full-turn sine of a 16-bit phase, Q16
	function automatic logic signed [17:0] phase_sine(input logic [15:0] p);
		logic [14:0] u;
		logic [17:0] m;
		u = p[14] ? 15'(15'd16384 - {1'b0, p[13:0]}) : {1'b0, p[13:0]};
		m = {1'b0, quarter_sine(u)};
		return p[15] ? $signed(-m) : $signed(m);
	endfunction

endpackage

// ===== hdl/sro_fifo.sv =====
module sro_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);

	logic [WIDTH-1:0]                   mem_q [sro_pkg::QUEUE_DEPTH];
	logic [sro_pkg::QUEUE_PTR_W-1:0]    wr_ptr_q;
	logic [sro_pkg::QUEUE_PTR_W-1:0]    rd_ptr_q;
	logic [sro_pkg::QUEUE_PTR_W:0]      count_q;
	logic                               do_push;
	logic                               do_pop;

	assign full       = (count_q == (sro_pkg::QUEUE_PTR_W+1)'(sro_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Store incoming requests
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/sro_front.sv =====
module sro_front #(
	parameter int START_ANGLE      = 0,
	parameter int TRIG_TABLE_DEPTH = 1024,
	parameter int IDX_W            = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [15:0]            range_sample,
	input  logic                   sample_valid,
	input  logic                   last_sample,
	input  sro_pkg::window_t       window,
	input  logic                   queue_full,
	output logic                   push,
	output sro_pkg::item_t         push_item,
	output logic [IDX_W-1:0]       push_idx
);

	localparam int DEPTH_W = $clog2(TRIG_TABLE_DEPTH + 1);

	logic [15:0]          angle_q;
	logic [15+DEPTH_W:0]  idx_prod;

	assign in_ready = !queue_full;
	assign push     = in_valid && in_ready;

	// Classify the sample against the range window
	assign push_item.range_mm  = range_sample;
	assign push_item.in_window = sample_valid && (range_sample >= window.floor_mm)
	                             && (range_sample <= window.ceil_mm);
	assign push_item.last      = last_sample;

	// Map the beam angle onto a table entry
	assign idx_prod = (16 + DEPTH_W)'(angle_q) * (16 + DEPTH_W)'(TRIG_TABLE_DEPTH);
	assign push_idx = idx_prod[16 +: IDX_W];

	// Advance the beam angle, restart it after the end of a scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= 16'(START_ANGLE);
		end else if (push) begin
			if (last_sample) begin
				angle_q <= 16'(START_ANGLE);
			end else begin
				angle_q <= angle_q + window.step;
			end
		end
	end

endmodule

// ===== hdl/sro_back.sv =====
module sro_back #(
	parameter int MAX_HITS         = 4096,
	parameter int TRIG_TABLE_DEPTH = 1024,
	parameter int IDX_W            = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  sro_pkg::item_t      head_item,
	input  logic [IDX_W-1:0]    head_idx,
	output logic                pop,
	input  sro_pkg::roi_t       roi,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [15:0]         nearest_distance,
	output logic                obstacle_detected,
	output logic [12:0]         hit_count
);

	localparam int HIT_W = $clog2(MAX_HITS + 1);

	logic signed [17:0] sin_rom [TRIG_TABLE_DEPTH];
	logic signed [17:0] cos_rom [TRIG_TABLE_DEPTH];

	logic               adv;

	logic               v_s1, last_s1, win_s1;
	logic [15:0]        rng_s1;
	logic signed [17:0] cos_s1, sin_s1;

	logic               v_s2, last_s2, win_s2;
	logic [15:0]        rng_s2;
	logic signed [34:0] x_s2, y_s2;

	logic               v_s3, last_s3, hit_s3;
	logic [15:0]        rng_s3;

	logic signed [34:0] x_lo, x_hi, y_lo, y_hi;

	logic [HIT_W-1:0]   hits_q, hits_nx;
	logic [15:0]        nearest_q, nearest_nx;
	logic [HIT_W+12:0]  hits_ext;
	logic [HIT_W+12:0]  thresh_ext;

	logic               out_valid_q;
	logic [15:0]        out_nearest_q;
	logic               out_det_q;
	logic [12:0]        out_hits_q;

	// Build the sine and cosine tables at elaboration
	for (genvar k = 0; k < TRIG_TABLE_DEPTH; k++) begin : g_rom
		localparam logic [15:0] PH =
			16'((64'(k) * 64'd65536) / 64'(TRIG_TABLE_DEPTH));
		localparam logic [15:0] PH_COS = 16'(17'(PH) + 17'd16384);
		localparam logic signed [17:0] SIN_V = sro_pkg::phase_sine(PH);
		localparam logic signed [17:0] COS_V = sro_pkg::phase_sine(PH_COS);
		assign sin_rom[k] = SIN_V;
		assign cos_rom[k] = COS_V;
	end

	// The whole back pipeline moves unless a result waits downstream
	assign adv = !out_valid_q || out_ready;
	assign pop = adv && head_valid;

	// Stage 1: table read
	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= head_item.last;
			win_s1  <= head_item.in_window;
			rng_s1  <= head_item.range_mm;
			cos_s1  <= cos_rom[head_idx];
			sin_s1  <= sin_rom[head_idx];
		end
	end

	// Stage 2: project onto x and y
	always_ff @(posedge clk) begin
		if (adv) begin
			last_s2 <= last_s1;
			win_s2  <= win_s1;
			rng_s2  <= rng_s1;
			x_s2    <= $signed({1'b0, rng_s1}) * cos_s1;
			y_s2    <= $signed({1'b0, rng_s1}) * sin_s1;
		end
	end

	// Scale the region bounds to Q16
	assign x_lo = {{2{roi.x_min[16]}}, roi.x_min, 16'b0};
	assign x_hi = {{2{roi.x_max[16]}}, roi.x_max, 16'b0};
	assign y_lo = {{2{roi.y_min[16]}}, roi.y_min, 16'b0};
	assign y_hi = {{2{roi.y_max[16]}}, roi.y_max, 16'b0};

	// Stage 3: region test
	always_ff @(posedge clk) begin
		if (adv) begin
			last_s3 <= last_s2;
			rng_s3  <= rng_s2;
			hit_s3  <= win_s2 && (x_s2 >= x_lo) && (x_s2 <= x_hi)
			           && (y_s2 >= y_lo) && (y_s2 <= y_hi);
		end
	end

	// Valid bits of the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= head_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Fold a hit into the scan totals
	always_comb begin
		hits_nx    = hits_q;
		nearest_nx = nearest_q;
		if (hit_s3) begin
			if (hits_q < HIT_W'(MAX_HITS)) begin
				hits_nx = hits_q + 1'b1;
			end
			if (rng_s3 < nearest_q) begin
				nearest_nx = rng_s3;
			end
		end
	end

	assign hits_ext   = {13'b0, hits_nx};
	assign thresh_ext = {{HIT_W{1'b0}}, roi.threshold};

	// Hold scan totals, clear them after the end of a scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q    <= '0;
			nearest_q <= 16'hFFFF;
		end else if (adv && v_s3) begin
			if (last_s3) begin
				hits_q    <= '0;
				nearest_q <= 16'hFFFF;
			end else begin
				hits_q    <= hits_nx;
				nearest_q <= nearest_nx;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s3 && last_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s3 && last_s3) begin
			out_nearest_q <= nearest_nx;
			out_det_q     <= (hits_ext >= thresh_ext);
			out_hits_q    <= hits_ext[12:0];
		end
	end

	assign out_valid         = out_valid_q;
	assign nearest_distance  = out_nearest_q;
	assign obstacle_detected = out_det_q;
	assign hit_count         = out_hits_q;

endmodule

// ===== hdl/scan_roi_obstacle_detect.sv =====
// Lidar region-of-interest obstacle detector.
//
// Input stream: one range sample per request. s_tdata[15:0] carries the
// range in millimetres, s_tuser marks a finite reading, s_tlast closes a
// scan. Output stream: one result per scan, sent for the request that
// carried s_tlast; m_tdata holds the nearest hit range (65535 when none),
// the detection flag and the saturating hit count.
// Configuration: cfg_we writes cfg_wdata to the register at cfg_addr;
// write only while no scan is in flight.
// Throughput: one sample per cycle while the queue is not full. With the
// queue empty, a result passes through the queue, then the table read,
// multiply, region test and output register stages to reach m_tvalid.
// A four-entry queue separates the input side from the arithmetic
// pipeline. When m_tready is low with a result waiting, the pipeline
// holds and the queue fills; s_tready drops only once the queue is full.
// Reset clears the scan totals, the queue and the stage valid bits, the beam
// angle returns to START_ANGLE and the configuration registers take their reset values.
module scan_roi_obstacle_detect #(
	parameter int START_ANGLE      = 0,
	parameter int MAX_HITS         = 4096,
	parameter int TRIG_TABLE_DEPTH = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [15:0]                        s_tdata,   // [15:0] range_sample
	input  logic                               s_tuser,   // [0] sample_valid
	input  logic                               s_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [15:0] nearest_distance, [16] obstacle_detected, [29:17] hit_count
	output logic [31:0]                        m_tdata,
	input  logic                               cfg_we,
	input  logic [sro_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [sro_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int IDX_W = $clog2(TRIG_TABLE_DEPTH);
	localparam int ENT_W = $bits(sro_pkg::item_t) + IDX_W;

	sro_pkg::window_t   window_q;
	sro_pkg::roi_t      roi_q;

	logic               queue_full;
	logic               push;
	sro_pkg::item_t     push_item;
	logic [IDX_W-1:0]   push_idx;
	logic               pop;
	logic               head_valid;
	logic [ENT_W-1:0]   head_data;
	sro_pkg::item_t     head_item;
	logic [IDX_W-1:0]   head_idx;

	logic [15:0]        nearest_distance;
	logic               obstacle_detected;
	logic [12:0]        hit_count;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roi_q.x_min        <= 17'sd0;
			roi_q.x_max        <= 17'sd2000;
			roi_q.y_min        <= -17'sd500;
			roi_q.y_max        <= 17'sd500;
			roi_q.threshold    <= 13'd1;
			window_q.floor_mm  <= 16'd0;
			window_q.ceil_mm   <= 16'd65534;
			window_q.step      <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_addr)
				sro_pkg::REG_ROI_X_MIN:   roi_q.x_min       <= cfg_wdata;
				sro_pkg::REG_ROI_X_MAX:   roi_q.x_max       <= cfg_wdata;
				sro_pkg::REG_ROI_Y_MIN:   roi_q.y_min       <= cfg_wdata;
				sro_pkg::REG_ROI_Y_MAX:   roi_q.y_max       <= cfg_wdata;
				sro_pkg::REG_HIT_THRESH:  roi_q.threshold   <= cfg_wdata[12:0];
				sro_pkg::REG_RANGE_FLOOR: window_q.floor_mm <= cfg_wdata[15:0];
				sro_pkg::REG_RANGE_CEIL:  window_q.ceil_mm  <= cfg_wdata[15:0];
				sro_pkg::REG_ANGLE_STEP:  window_q.step     <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	sro_front #(
		.START_ANGLE      (START_ANGLE),
		.TRIG_TABLE_DEPTH (TRIG_TABLE_DEPTH),
		.IDX_W            (IDX_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.range_sample (s_tdata),
		.sample_valid (s_tuser),
		.last_sample  (s_tlast),
		.window       (window_q),
		.queue_full   (queue_full),
		.push         (push),
		.push_item    (push_item),
		.push_idx     (push_idx)
	);

	sro_fifo #(
		.WIDTH (ENT_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  ({push_idx, push_item}),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	assign head_item = head_data[$bits(sro_pkg::item_t)-1:0];
	assign head_idx  = head_data[ENT_W-1 -: IDX_W];

	sro_back #(
		.MAX_HITS         (MAX_HITS),
		.TRIG_TABLE_DEPTH (TRIG_TABLE_DEPTH),
		.IDX_W            (IDX_W)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.head_valid        (head_valid),
		.head_item         (head_item),
		.head_idx          (head_idx),
		.pop               (pop),
		.roi               (roi_q),
		.out_valid         (m_tvalid),
		.out_ready         (m_tready),
		.nearest_distance  (nearest_distance),
		.obstacle_detected (obstacle_detected),
		.hit_count         (hit_count)
	);

	assign m_tdata = {2'b00, hit_count, obstacle_detected, nearest_distance};

endmodule

// ===== sim/scan_roi_obstacle_detect_test.sv =====
`timescale 1ns / 100ps

module scan_roi_obstacle_detect_test;

	localparam int START_ANGLE        = 0;
	localparam int MAX_HITS           = 4096;
	localparam int TRIG_TABLE_DEPTH   = 1024;
	localparam int RANDOM_SAMPLES     = 1300;
	localparam int SETTLE_CYCLES      = 8;
	localparam int QUIET_LIMIT        = 2000;
	localparam int MAX_PRINTED        = 40;

	typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

	// What one scan reports
	typedef struct packed {
		logic [15:0] nearest;
		logic        detected;
		logic [12:0] hits;
	} scan_summary_t;

	// One line of the directed plan: a register write or a sample request
	typedef struct packed {
		row_kind_t          kind;
		logic [2:0]         reg_idx;
		logic signed [16:0] value;
		logic [15:0]        range_mm;
		logic               finite;
		logic               closes_scan;
		logic               typed;
		scan_summary_t      summary;
	} plan_row_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [15:0]                    s_tdata   = '0;
	logic                           s_tuser   = 1'b0;
	logic                           s_tlast   = 1'b0;
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [31:0]                    m_tdata;
	logic                           cfg_we    = 1'b0;
	logic [sro_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [sro_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	// Shadow copy of the settings and of the scan in progress
	logic signed [16:0] x_lo, x_hi, y_lo, y_hi;
	logic [12:0]        detect_at;
	logic [15:0]        window_lo, window_hi, step_size;
	logic [15:0]        angle;
	logic [12:0]        hits_now;
	logic [15:0]        nearest_now;

	scan_summary_t summaries_due[$];
	plan_row_t     plan[$];

	int errors         = 0;
	int samples_sent   = 0;
	int scans_checked  = 0;
	int obstacle_scans = 0;
	int reg_writes     = 0;
	int quiet          = 0;
	int stall_left     = 0;
	int gap_chance     = 20;
	int stall_chance   = 20;

	scan_roi_obstacle_detect #(
		.START_ANGLE(START_ANGLE),
		.MAX_HITS(MAX_HITS),
		.TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Sine on a quarter wave, Q16, from the odd Q30 polynomial in Horner form
	function automatic logic [16:0] quarter_wave(input logic [14:0] u);
		logic [63:0] coef [5];
		logic [63:0] t, t2, acc;
		coef = '{sro_pkg::C9, sro_pkg::C7, sro_pkg::C5, sro_pkg::C3, sro_pkg::C1};
		t    = 64'(u) << 16;
		t2   = (t * t) >> 30;
		acc  = coef[0];
		for (int i = 1; i < 5; i++) begin
			acc = coef[i] - ((t2 * acc) >> 30);
		end
		acc = (t * acc) >> 30;
		if (acc > sro_pkg::Q30_ONE) begin
			acc = sro_pkg::Q30_ONE;
		end
		acc = (acc + 64'd8192) >> 14;
		return (acc > 64'd65536) ? 17'd65536 : acc[16:0];
	endfunction

	// Fold a full-turn phase onto the quarter wave and restore the sign
	function automatic longint wave_q16(input logic [15:0] ph);
		logic [14:0] u;
		longint      mag;
		u   = ph[14] ? 15'(16384 - ph[13:0]) : 15'(ph[13:0]);
		mag = longint'(quarter_wave(u));
		return ph[15] ? -mag : mag;
	endfunction

	function automatic void clear_scan();
		angle       = 16'(START_ANGLE);
		hits_now    = '0;
		nearest_now = 16'hFFFF;
	endfunction

	// Advance the scan by one sample; return 1 when the sample closes the scan
	function automatic bit step_scan(input logic [15:0] range_mm, input logic finite,
			input logic closes_scan, output scan_summary_t summary);
		longint idx, phase, x, y;
		idx = (longint'(angle) * TRIG_TABLE_DEPTH) >> 16;
		if (idx >= TRIG_TABLE_DEPTH) begin
			idx = TRIG_TABLE_DEPTH - 1;
		end
		phase = (idx * 65536) / TRIG_TABLE_DEPTH;
		x = longint'(range_mm) * wave_q16(16'(phase + 16384));
		y = longint'(range_mm) * wave_q16(16'(phase));
		if (finite && range_mm >= window_lo && range_mm <= window_hi
				&& x >= longint'(x_lo) * 65536 && x <= longint'(x_hi) * 65536
				&& y >= longint'(y_lo) * 65536 && y <= longint'(y_hi) * 65536) begin
			if (hits_now < MAX_HITS) begin
				hits_now++;
			end
			if (range_mm < nearest_now) begin
				nearest_now = range_mm;
			end
		end
		angle   = angle + step_size;
		summary = '{nearest_now, hits_now >= detect_at, hits_now};
		if (closes_scan) begin
			clear_scan();
		end
		return closes_scan;
	endfunction

	// Append one line to the directed plan
	function automatic void add_row(input plan_row_t row);
		plan.insert(plan.size(), row);
	endfunction

	function automatic plan_row_t cfg_row(input logic [2:0] idx, input int value);
		plan_row_t row;
		row         = '0;
		row.kind    = ROW_CFG;
		row.reg_idx = idx;
		row.value   = 17'(value);
		return row;
	endfunction

	function automatic plan_row_t sample_row(input logic [15:0] range_mm,
			input logic finite, input logic closes_scan);
		plan_row_t row;
		row             = '0;
		row.kind        = ROW_SAMPLE;
		row.range_mm    = range_mm;
		row.finite      = finite;
		row.closes_scan = closes_scan;
		return row;
	endfunction

	// Closing sample whose scan result is written out by hand
	function automatic plan_row_t known_row(input logic [15:0] range_mm, input logic finite,
			input logic [15:0] nearest, input logic detected, input logic [12:0] hits);
		plan_row_t row;
		row         = sample_row(range_mm, finite, 1'b1);
		row.typed   = 1'b1;
		row.summary = '{nearest, detected, hits};
		return row;
	endfunction

	function automatic logic signed [16:0] pick_bound();
		case ($urandom_range(0, 7))
			0: return -17'sd65535;
			1: return 17'sd65535;
			2, 3, 4: return 17'($signed($urandom_range(0, 6000)) - 3000);
			default: return 17'($signed($urandom_range(0, 131070)) - 65535);
		endcase
	endfunction

	function automatic int pick_idle();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 10;
			2: return 25;
			default: return 50;
		endcase
	endfunction

	task automatic flag_mismatch(input string what);
		errors++;
		if (errors <= MAX_PRINTED) begin
			$display("mismatch %0d at %0t: %s", errors, $time, what);
		end
	endtask

	// Write one register and keep the shadow copy in step
	task automatic write_reg(input logic [2:0] idx, input logic signed [16:0] value);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			sro_pkg::REG_ROI_X_MIN:   x_lo = value;
			sro_pkg::REG_ROI_X_MAX:   x_hi = value;
			sro_pkg::REG_ROI_Y_MIN:   y_lo = value;
			sro_pkg::REG_ROI_Y_MAX:   y_hi = value;
			sro_pkg::REG_HIT_THRESH:  detect_at = value[12:0];
			sro_pkg::REG_RANGE_FLOOR: window_lo = value[15:0];
			sro_pkg::REG_RANGE_CEIL:  window_hi = value[15:0];
			sro_pkg::REG_ANGLE_STEP:  step_size = value[15:0];
			default: ;
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	// Hold the input side until every pending result is out, then let the pipe empty
	task automatic drain();
		s_tvalid <= 1'b0;
		while (summaries_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Offer one sample request, wait for it to be taken and predict its result
	task automatic send_sample(input logic [15:0] range_mm, input logic finite,
			input logic closes_scan, input logic typed, input scan_summary_t typed_summary);
		scan_summary_t summary;
		if (gap_chance != 0 && $urandom_range(0, 99) < gap_chance) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= range_mm;
		s_tuser  <= finite;
		s_tlast  <= closes_scan;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		samples_sent++;
		if (step_scan(range_mm, finite, closes_scan, summary)) begin
			summaries_due.insert(summaries_due.size(), typed ? typed_summary : summary);
		end
	endtask

	// Check results, stall the output side and watch for a hang
	always @(posedge clk) begin
		scan_summary_t want;
		bit            moved;
		if (arst_n) begin
			moved = (s_tvalid && s_tready) || (m_tvalid && m_tready);
			if (m_tvalid && m_tready) begin
				if (summaries_due.size() == 0) begin
					flag_mismatch($sformatf("result %h with no scan pending", m_tdata));
				end else begin
					want = summaries_due.pop_front();
					scans_checked++;
					if (want.detected) begin
						obstacle_scans++;
					end
					if (m_tdata[15:0] !== want.nearest) begin
						flag_mismatch($sformatf("nearest_distance %0d, want %0d",
							m_tdata[15:0], want.nearest));
					end
					if (m_tdata[16] !== want.detected) begin
						flag_mismatch($sformatf("obstacle_detected %b, want %b",
							m_tdata[16], want.detected));
					end
					if (m_tdata[29:17] !== want.hits) begin
						flag_mismatch($sformatf("hit_count %0d, want %0d",
							m_tdata[29:17], want.hits));
					end
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				m_tready <= (stall_left == 0);
			end else if (stall_chance != 0 && $urandom_range(0, 99) < stall_chance) begin
				stall_left = $urandom_range(1, 8);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
			quiet = moved ? 0 : quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("timeout: no request moved for %0d cycles", quiet);
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic signed [16:0] lo, hi;
		logic [15:0]        range_mm;
		int                 random_sent, phase_len, phase_sent, scan_len, value;
		bit                 noisy, closes;

		x_lo      = 17'sd0;
		x_hi      = 17'sd2000;
		y_lo      = -17'sd500;
		y_hi      = 17'sd500;
		detect_at = 13'd1;
		window_lo = 16'd0;
		window_hi = 16'd65534;
		step_size = 16'd0;
		clear_scan();

		// Reset settings keep the beam at zero: x is the range and y is zero
		add_row(known_row(0, 1'b1, 0, 1'b1, 1));
		add_row(known_row(65535, 1'b1, 65535, 1'b0, 0));
		add_row(sample_row(1500, 1'b0, 1'b0));
		add_row(sample_row(2000, 1'b1, 1'b0));
		add_row(known_row(2001, 1'b1, 2000, 1'b1, 1));
		add_row(known_row(100, 1'b0, 65535, 1'b0, 0));
		add_row(known_row(65534, 1'b1, 65535, 1'b0, 0));
		// a hit at the top of the range reads the same as no hit
		add_row(cfg_row(sro_pkg::REG_RANGE_CEIL, 65535));
		add_row(cfg_row(sro_pkg::REG_ROI_X_MAX, 65535));
		add_row(known_row(65535, 1'b1, 65535, 1'b1, 1));
		// zero threshold detects an empty scan
		add_row(cfg_row(sro_pkg::REG_HIT_THRESH, 0));
		add_row(known_row(7, 1'b0, 65535, 1'b1, 0));
		// empty range window
		add_row(cfg_row(sro_pkg::REG_HIT_THRESH, 1));
		add_row(cfg_row(sro_pkg::REG_RANGE_FLOOR, 3000));
		add_row(cfg_row(sro_pkg::REG_RANGE_CEIL, 2000));
		add_row(sample_row(2500, 1'b1, 1'b0));
		add_row(known_row(3000, 1'b1, 65535, 1'b0, 0));
		// empty region
		add_row(cfg_row(sro_pkg::REG_RANGE_FLOOR, 0));
		add_row(cfg_row(sro_pkg::REG_RANGE_CEIL, 65535));
		add_row(cfg_row(sro_pkg::REG_ROI_X_MIN, 100));
		add_row(cfg_row(sro_pkg::REG_ROI_X_MAX, 50));
		add_row(known_row(75, 1'b1, 65535, 1'b0, 0));
		// widest region, quarter-turn steps wrap the angle
		add_row(cfg_row(sro_pkg::REG_ROI_X_MIN, -65535));
		add_row(cfg_row(sro_pkg::REG_ROI_X_MAX, 65535));
		add_row(cfg_row(sro_pkg::REG_ROI_Y_MIN, -65535));
		add_row(cfg_row(sro_pkg::REG_ROI_Y_MAX, 65535));
		add_row(cfg_row(sro_pkg::REG_ANGLE_STEP, 16384));
		add_row(sample_row(1000, 1'b1, 1'b0));
		add_row(sample_row(2000, 1'b1, 1'b0));
		add_row(sample_row(3000, 1'b1, 1'b0));
		add_row(sample_row(4000, 1'b1, 1'b0));
		add_row(sample_row(500, 1'b1, 1'b1));
		// largest step walks the beam backward by one unit
		add_row(cfg_row(sro_pkg::REG_ROI_X_MIN, 0));
		add_row(cfg_row(sro_pkg::REG_ROI_X_MAX, 2000));
		add_row(cfg_row(sro_pkg::REG_ROI_Y_MIN, -500));
		add_row(cfg_row(sro_pkg::REG_ROI_Y_MAX, 500));
		add_row(cfg_row(sro_pkg::REG_ANGLE_STEP, 65535));
		add_row(sample_row(1200, 1'b1, 1'b0));
		add_row(sample_row(1100, 1'b1, 1'b0));
		add_row(sample_row(65535, 1'b1, 1'b1));
		// sweep across the region with a coarse step
		add_row(cfg_row(sro_pkg::REG_ANGLE_STEP, 1000));
		add_row(cfg_row(sro_pkg::REG_HIT_THRESH, 3));
		add_row(sample_row(300, 1'b1, 1'b0));
		add_row(sample_row(900, 1'b1, 1'b0));
		add_row(sample_row(1500, 1'b0, 1'b0));
		add_row(sample_row(600, 1'b1, 1'b0));
		add_row(sample_row(1800, 1'b1, 1'b1));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed plan
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				drain();
				write_reg(plan[i].reg_idx, plan[i].value);
			end else begin
				send_sample(plan[i].range_mm, plan[i].finite, plan[i].closes_scan,
					plan[i].typed, plan[i].summary);
			end
		end

		// Random phases: fresh settings, then whole scans with random content
		random_sent = 0;
		while (random_sent < RANDOM_SAMPLES) begin
			drain();
			lo = pick_bound();
			hi = pick_bound();
			if (lo > hi && $urandom_range(0, 7) != 0) begin
				{lo, hi} = {hi, lo};
			end
			write_reg(sro_pkg::REG_ROI_X_MIN, lo);
			write_reg(sro_pkg::REG_ROI_X_MAX, hi);
			lo = pick_bound();
			hi = pick_bound();
			if (lo > hi && $urandom_range(0, 7) != 0) begin
				{lo, hi} = {hi, lo};
			end
			write_reg(sro_pkg::REG_ROI_Y_MIN, lo);
			write_reg(sro_pkg::REG_ROI_Y_MAX, hi);
			case ($urandom_range(0, 5))
				0: value = 0;
				1: value = MAX_HITS;
				2: value = $urandom_range(0, MAX_HITS);
				default: value = $urandom_range(1, 6);
			endcase
			write_reg(sro_pkg::REG_HIT_THRESH, 17'(value));
			case ($urandom_range(0, 4))
				0: value = 0;
				1: value = $urandom_range(0, 65535);
				default: value = $urandom_range(0, 400);
			endcase
			write_reg(sro_pkg::REG_RANGE_FLOOR, 17'(value));
			case ($urandom_range(0, 4))
				0: value = 65535;
				1: value = 65534;
				2: value = $urandom_range(0, 65535);
				default: value = $urandom_range(2000, 65535);
			endcase
			write_reg(sro_pkg::REG_RANGE_CEIL, 17'(value));
			case ($urandom_range(0, 4))
				0: value = 0;
				1: value = 65535;
				2: value = $urandom_range(0, 65535);
				default: value = $urandom_range(1, 700);
			endcase
			write_reg(sro_pkg::REG_ANGLE_STEP, 17'(value));

			// no idling on either side toward the end of the run
			if (random_sent >= RANDOM_SAMPLES - 400) begin
				gap_chance   = 0;
				stall_chance = 0;
			end else begin
				gap_chance   = pick_idle();
				stall_chance = pick_idle();
			end

			phase_len  = $urandom_range(60, 200);
			phase_sent = 0;
			while (phase_sent < phase_len) begin
				scan_len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120)
					: $urandom_range(1, 40);
				noisy = ($urandom_range(0, 9) == 0);
				for (int k = 0; k < scan_len; k++) begin
					case ($urandom_range(0, 7))
						0: range_mm = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
						1, 2: range_mm = 16'($urandom);
						default: range_mm = 16'($urandom_range(0, 3000));
					endcase
					// noise ends scans early and flips validity at random
					closes = (k == scan_len - 1) || (noisy && $urandom_range(0, 7) == 0);
					send_sample(range_mm,
						noisy ? 1'($urandom_range(0, 1)) : 1'($urandom_range(0, 7) != 0),
						closes, 1'b0, '0);
				end
				phase_sent += scan_len;
			end
			random_sent += phase_sent;
		end

		drain();
		$display("%0d samples sent, %0d scan results checked, %0d with an obstacle",
			samples_sent, scans_checked, obstacle_scans);
		$display("%0d register writes across empty windows and regions, edge thresholds and wrapping steps",
			reg_writes);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
